// ----- design/cfsm_pkg.sv -----
// shared types, codes and the error code exemption check for the shun monitor
package cfsm_pkg;

    // action codes
    localparam logic [1:0] ACT_CONNECT_ERROR = 2'd0;
    localparam logic [1:0] ACT_KILL_ALL      = 2'd1;
    localparam logic [1:0] ACT_SET_STATUS    = 2'd2;
    localparam logic [1:0] ACT_UNUSED        = 2'd3;

    // server status codes
    localparam logic [1:0] ST_ONLINE  = 2'd0;
    localparam logic [1:0] ST_SHUNNED = 2'd1;
    localparam logic [1:0] ST_OTHER   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRIES = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHUN    = 1'd1;

    // configuration reset values
    localparam logic [9:0]  RETRIES_RESET = 10'd10;
    localparam logic [15:0] SHUN_RESET    = 16'd5;

    // queue depth between the stages and at the result side
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // input word
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] err_num;
        logic [31:0] now_sec;
        logic [1:0]  new_status;
    } item_t;

    // result word
    typedef struct packed {
        logic [1:0]  server_state;
        logic        auto_shun;
        logic        kill_all_flag;
        logic        shunned_now;
        logic        counted;
        logic [15:0] burst_count;
        logic [31:0] error_total;
    } result_t;

    // classified command from the front to the back
    typedef struct packed {
        logic [1:0]  action;
        logic        exempt;
        logic [31:0] now_sec;
        logic [1:0]  new_status;
    } cmd_t;

    // error codes that never count toward shunning
    function automatic logic code_is_exempt(input logic [15:0] e);
        logic hit;
        hit = 1'b0;
        if (e >= 16'd1048 && e <= 16'd1052) hit = 1'b1;
        if (e >= 16'd1054 && e <= 16'd1075) hit = 1'b1;
        if (e >= 16'd1099 && e <= 16'd1104) hit = 1'b1;
        if (e >= 16'd1106 && e <= 16'd1113) hit = 1'b1;
        if (e >= 16'd1116 && e <= 16'd1118) hit = 1'b1;
        if (e == 16'd1136) hit = 1'b1;
        if (e >= 16'd1138 && e <= 16'd1149) hit = 1'b1;
        if (e == 16'd1007 || e == 16'd1008 || e == 16'd1044 || e == 16'd1045) hit = 1'b1;
        if (e == 16'd1120 || e == 16'd1203 || e == 16'd1226 || e == 16'd3118) hit = 1'b1;
        return hit;
    endfunction

endpackage

// ----- design/cfsm_front.sv -----
// front stage: accepts input words, classifies them and queues commands
module cfsm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cfsm_pkg::item_t   item,
    input  logic              cmd_take,
    output logic              cmd_valid,
    output cfsm_pkg::cmd_t    cmd
);

    cfsm_pkg::cmd_t                     q_mem [cfsm_pkg::QDEPTH];
    logic [cfsm_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [cfsm_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [cfsm_pkg::QCNT_W-1:0]        count_reg, count_next;
    cfsm_pkg::cmd_t                     classified;
    logic                               do_push;
    logic                               do_pop;

    // classify the incoming word
    always_comb
    begin
        classified.action     = item.action;
        classified.exempt     = cfsm_pkg::code_is_exempt(item.err_num);
        classified.now_sec    = item.now_sec;
        classified.new_status = (item.new_status > cfsm_pkg::ST_OTHER) ?
                                cfsm_pkg::ST_OTHER : item.new_status;
    end

    assign full      = (count_reg == cfsm_pkg::QCNT_W'(cfsm_pkg::QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == cfsm_pkg::QPTR_W'(cfsm_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cfsm_pkg::QPTR_W'(cfsm_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // queue control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ----- design/cfsm_exec.sv -----
// back stage: server state update, configuration registers and result queue
module cfsm_exec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cfsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              cmd_valid,
    input  cfsm_pkg::cmd_t                    cmd,
    output logic                              cmd_take,
    input  logic                              pop,
    output logic                              empty,
    output cfsm_pkg::result_t                 result
);

    logic [9:0]                    retries_reg;
    logic [15:0]                   shun_reg;
    logic [1:0]                    status_reg, status_next;
    logic [31:0]                   last_sec_reg, last_sec_next;
    logic [15:0]                   burst_reg, burst_next;
    logic [31:0]                   total_reg, total_next;
    logic                          auto_reg, auto_next;
    logic                          kill_reg, kill_next;
    logic                          counted;
    logic [16:0]                   lim_retry;
    logic [16:0]                   lim_shun;
    logic [16:0]                   limit;
    logic [15:0]                   burst_inc;
    cfsm_pkg::result_t             res_new;
    cfsm_pkg::result_t             r_mem [cfsm_pkg::QDEPTH];
    logic [cfsm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [cfsm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [cfsm_pkg::QCNT_W-1:0]   count_reg;
    logic                          out_full;
    logic                          fire;
    logic                          do_pop;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retries_reg <= cfsm_pkg::RETRIES_RESET;
            shun_reg    <= cfsm_pkg::SHUN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == cfsm_pkg::REG_RETRIES)
            begin
                retries_reg <= cfg_wdata[9:0];
            end
            if (cfg_addr == cfsm_pkg::REG_SHUN)
            begin
                shun_reg <= cfg_wdata;
            end
        end
    end

    // shun threshold is the smaller of the two limits
    assign lim_retry = {7'd0, retries_reg} + 17'd1;
    assign lim_shun  = {1'b0, shun_reg};
    assign limit     = (lim_shun < lim_retry) ? lim_shun : lim_retry;
    assign burst_inc = (burst_reg == 16'hFFFF) ? burst_reg : burst_reg + 16'd1;

    assign out_full = (count_reg == cfsm_pkg::QCNT_W'(cfsm_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign fire     = cmd_valid && !out_full;
    assign cmd_take = fire;
    assign do_pop   = pop && !empty;

    // state update for one command
    always_comb
    begin
        status_next   = status_reg;
        last_sec_next = last_sec_reg;
        burst_next    = burst_reg;
        total_next    = total_reg;
        auto_next     = auto_reg;
        kill_next     = kill_reg;
        counted       = 1'b0;
        if (cmd_valid)
        begin
            unique case (cmd.action)
                cfsm_pkg::ACT_CONNECT_ERROR:
                begin
                    if (total_reg != 32'hFFFF_FFFF)
                    begin
                        total_next = total_reg + 32'd1;
                    end
                    if (!cmd.exempt)
                    begin
                        if (cmd.now_sec > last_sec_reg)
                        begin
                            last_sec_next = cmd.now_sec;
                            burst_next    = 16'd1;
                            counted       = 1'b1;
                        end
                        else if (cmd.now_sec == last_sec_reg)
                        begin
                            burst_next = burst_inc;
                            counted    = 1'b1;
                            if ({1'b0, burst_inc} >= limit &&
                                status_reg == cfsm_pkg::ST_ONLINE)
                            begin
                                status_next = cfsm_pkg::ST_SHUNNED;
                                auto_next   = 1'b1;
                            end
                        end
                    end
                end
                cfsm_pkg::ACT_KILL_ALL:
                begin
                    status_next = cfsm_pkg::ST_SHUNNED;
                    auto_next   = 1'b1;
                    kill_next   = 1'b1;
                end
                cfsm_pkg::ACT_SET_STATUS:
                begin
                    status_next = cmd.new_status;
                end
                cfsm_pkg::ACT_UNUSED:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    // result word for this command
    always_comb
    begin
        res_new.server_state  = status_next;
        res_new.auto_shun     = auto_next;
        res_new.kill_all_flag = kill_next;
        res_new.shunned_now   = (status_reg == cfsm_pkg::ST_ONLINE) &&
                                (status_next == cfsm_pkg::ST_SHUNNED);
        res_new.counted       = counted;
        res_new.burst_count   = burst_next;
        res_new.error_total   = total_next;
    end

    // server state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg   <= cfsm_pkg::ST_ONLINE;
            last_sec_reg <= '0;
            burst_reg    <= '0;
            total_reg    <= '0;
            auto_reg     <= 1'b0;
            kill_reg     <= 1'b0;
        end
        else if (fire)
        begin
            status_reg   <= status_next;
            last_sec_reg <= last_sec_next;
            burst_reg    <= burst_next;
            total_reg    <= total_next;
            auto_reg     <= auto_next;
            kill_reg     <= kill_next;
        end
    end

    // result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == cfsm_pkg::QPTR_W'(cfsm_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == cfsm_pkg::QPTR_W'(cfsm_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (fire && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            r_mem[wr_ptr_reg] <= res_new;
        end
    end

    assign result = r_mem[rd_ptr_reg];

endmodule

// ----- design/connect_failure_shun_monitor.sv -----
// top level of the connection failure shun monitor
// a pushed word passes the front queue, then the state update into the result queue,
// before its result is readable; throughput: one word per cycle while the result
// queue is not full, set by the single state update in the back stage
// reset: rst_n clears both queues, the server state and the counters, and loads the
// configuration registers with their defaults (retries 10, shun threshold 5)
module connect_failure_shun_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  cfsm_pkg::item_t                   item,
    output logic                              empty,
    input  logic                              pop,
    output cfsm_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [cfsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cfsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic             cmd_valid;
    logic             cmd_take;
    cfsm_pkg::cmd_t   cmd;

    // classify and queue
    cfsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_take  (cmd_take),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // update state and queue results
    cfsm_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ----- design/cfsm_checker.sv -----
// port level checks on the shun monitor results
module cfsm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop,
    input  logic               empty,
    input  cfsm_pkg::result_t  result
);

    logic [31:0] last_total_reg;
    logic        seen_reg;

    // remember the error total of the last word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else if (pop && !empty)
        begin
            last_total_reg <= result.error_total;
            seen_reg       <= 1'b1;
        end
    end

    // error total never goes down between words
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && seen_reg) |-> (result.error_total >= last_total_reg))
        else $error("error total decreased");

    // a fresh shun leaves the server shunned
    a_shun_state: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.shunned_now) |-> (result.server_state == cfsm_pkg::ST_SHUNNED))
        else $error("shunned_now without shunned state");

    // kill-all always comes with the automatic mark
    a_kill_auto: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kill_all_flag) |-> result.auto_shun)
        else $error("kill-all mark without automatic mark");

    // a counted error leaves a nonzero burst count
    a_counted_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.counted) |-> (result.burst_count != 16'd0))
        else $error("counted error with zero burst count");

endmodule

bind connect_failure_shun_monitor cfsm_checker u_cfsm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

// ----- bench/testbench.sv -----
// self-checking testbench for the connection failure shun monitor
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_WORDS = 270;
    localparam int unsigned BURST_WORDS = 200;

    // clock, reset and block inputs
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [cfsm_pkg::CFG_ADDR_W-1:0] cfg_addr = cfsm_pkg::REG_RETRIES;
    logic [cfsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    cfsm_pkg::item_t item_word = '0;
    logic full;
    logic empty;
    cfsm_pkg::result_t result_word;

    // shadow of the monitor state and its configuration
    logic [1:0] srv_status;
    logic [31:0] last_sec;
    logic [15:0] burst;
    logic [31:0] err_total;
    logic auto_mark;
    logic kill_mark;
    logic [9:0] cfg_retries;
    logic [15:0] cfg_shun;

    cfsm_pkg::result_t pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int unsigned rx_stall;

    connect_failure_shun_monitor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item_word),
        .empty     (empty),
        .pop       (pop),
        .result    (result_word),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // error codes that never count toward shunning
    function automatic bit exempt_code(input logic [15:0] c);
        case (c)
            16'd1007, 16'd1008, 16'd1044, 16'd1045, 16'd1120,
            16'd1136, 16'd1203, 16'd1226, 16'd3118: return 1'b1;
            default: return (c >= 16'd1048 && c <= 16'd1052) ||
                            (c >= 16'd1054 && c <= 16'd1075) ||
                            (c >= 16'd1099 && c <= 16'd1104) ||
                            (c >= 16'd1106 && c <= 16'd1113) ||
                            (c >= 16'd1116 && c <= 16'd1118) ||
                            (c >= 16'd1138 && c <= 16'd1149);
        endcase
    endfunction

    // random code from the exempt set
    function automatic logic [15:0] pick_exempt_code();
        logic [15:0] c;
        case ($urandom_range(0, 6))
            0: c = 16'd1048 + 16'($urandom_range(0, 4));
            1: c = 16'd1054 + 16'($urandom_range(0, 21));
            2: c = 16'd1099 + 16'($urandom_range(0, 5));
            3: c = 16'd1106 + 16'($urandom_range(0, 7));
            4: c = 16'd1116 + 16'($urandom_range(0, 2));
            5: c = 16'd1138 + 16'($urandom_range(0, 11));
            default:
            begin
                case ($urandom_range(0, 8))
                    0: c = 16'd1007;
                    1: c = 16'd1008;
                    2: c = 16'd1044;
                    3: c = 16'd1045;
                    4: c = 16'd1120;
                    5: c = 16'd1136;
                    6: c = 16'd1203;
                    7: c = 16'd1226;
                    default: c = 16'd3118;
                endcase
            end
        endcase
        return c;
    endfunction

    task automatic reset_model();
        srv_status = cfsm_pkg::ST_ONLINE;
        last_sec = '0;
        burst = '0;
        err_total = '0;
        auto_mark = 1'b0;
        kill_mark = 1'b0;
        cfg_retries = cfsm_pkg::RETRIES_RESET;
        cfg_shun = cfsm_pkg::SHUN_RESET;
    endtask

    // advance the shadow state by one word and return the expected result
    function automatic cfsm_pkg::result_t predict_word(input cfsm_pkg::item_t w);
        cfsm_pkg::result_t r;
        logic [1:0] prior;
        logic [16:0] thresh;
        logic hit;
        prior = srv_status;
        hit = 1'b0;
        case (w.action)
            cfsm_pkg::ACT_CONNECT_ERROR:
            begin
                if (err_total != 32'hFFFF_FFFF)
                    err_total = err_total + 32'd1;
                if (!exempt_code(w.err_num))
                begin
                    if (w.now_sec > last_sec)
                    begin
                        // a new second restarts the burst
                        last_sec = w.now_sec;
                        burst = 16'd1;
                        hit = 1'b1;
                    end
                    else if (w.now_sec == last_sec)
                    begin
                        hit = 1'b1;
                        thresh = {7'd0, cfg_retries} + 17'd1;
                        if ({1'b0, cfg_shun} < thresh)
                            thresh = {1'b0, cfg_shun};
                        if (burst != 16'hFFFF)
                            burst = burst + 16'd1;
                        if ({1'b0, burst} >= thresh && srv_status == cfsm_pkg::ST_ONLINE)
                        begin
                            srv_status = cfsm_pkg::ST_SHUNNED;
                            auto_mark = 1'b1;
                        end
                    end
                end
            end
            cfsm_pkg::ACT_KILL_ALL:
            begin
                srv_status = cfsm_pkg::ST_SHUNNED;
                auto_mark = 1'b1;
                kill_mark = 1'b1;
            end
            cfsm_pkg::ACT_SET_STATUS:
                srv_status = (w.new_status > cfsm_pkg::ST_OTHER) ? cfsm_pkg::ST_OTHER
                                                                 : w.new_status;
            default: ;
        endcase
        r.server_state = srv_status;
        r.auto_shun = auto_mark;
        r.kill_all_flag = kill_mark;
        r.shunned_now = (prior == cfsm_pkg::ST_ONLINE && srv_status == cfsm_pkg::ST_SHUNNED);
        r.counted = hit;
        r.burst_count = burst;
        r.error_total = err_total;
        return r;
    endfunction

    function automatic cfsm_pkg::item_t mk_word(input logic [1:0] act,
                                                input logic [15:0] code,
                                                input logic [31:0] sec,
                                                input logic [1:0] st);
        cfsm_pkg::item_t w;
        w.action = act;
        w.err_num = code;
        w.now_sec = sec;
        w.new_status = st;
        return w;
    endfunction

    // random word, mostly errors around the last counted second
    function automatic cfsm_pkg::item_t random_word();
        cfsm_pkg::item_t w;
        int unsigned roll;
        w = mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'($urandom_range(0, 65535)), last_sec,
                    2'($urandom_range(0, 3)));
        roll = $urandom_range(0, 99);
        if (roll < 5)
            w.action = cfsm_pkg::ACT_KILL_ALL;
        else if (roll < 15)
        begin
            w.action = cfsm_pkg::ACT_SET_STATUS;
            if ($urandom_range(0, 1) == 1)
                w.new_status = cfsm_pkg::ST_ONLINE;
        end
        else if (roll < 18)
            w.action = cfsm_pkg::ACT_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            w.err_num = pick_exempt_code();
        else if (roll < 30)
            w.err_num = 16'($urandom_range(1000, 1250));
        roll = $urandom_range(0, 99);
        if (roll < 20)
            w.now_sec = last_sec + $urandom_range(1, 3);
        else if (roll < 25)
            w.now_sec = last_sec - $urandom_range(1, 1000);
        else if (roll < 28)
            w.now_sec = $urandom;
        return w;
    endfunction

    function automatic int unsigned pick_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // offer one word and wait until the block takes it
    task automatic send_word(input cfsm_pkg::item_t w);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_results.push_back(predict_word(w));
    endtask

    // stop offering and let every expected result come out
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers while the block is idle
    task automatic set_config(input logic [9:0] retries, input logic [15:0] shun);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= cfsm_pkg::REG_RETRIES;
        cfg_wdata <= {6'd0, retries};
        @(posedge clk);
        cfg_addr <= cfsm_pkg::REG_SHUN;
        cfg_wdata <= shun;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_retries = retries;
        cfg_shun = shun;
        @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input cfsm_pkg::result_t got);
        cfsm_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result word expected none actual %h", $time, got);
        end
        else
        begin
            want = pending_results.pop_front();
            report_field("server_state", 32'(want.server_state), 32'(got.server_state));
            report_field("auto_shun", 32'(want.auto_shun), 32'(got.auto_shun));
            report_field("kill_all_flag", 32'(want.kill_all_flag), 32'(got.kill_all_flag));
            report_field("shunned_now", 32'(want.shunned_now), 32'(got.shunned_now));
            report_field("counted", 32'(want.counted), 32'(got.counted));
            report_field("burst_count", 32'(want.burst_count), 32'(got.burst_count));
            report_field("error_total", want.error_total, got.error_total);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                rx_stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                rx_stall = pick_gap();
            if (rx_stall > 0)
            begin
                pop <= 1'b0;
                repeat (rx_stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            check_result(result_word);
        end
    end

    // exempt codes, burst up to the default threshold, status writes, kill-all
    task automatic test_directed();
        send_word(mk_word(cfsm_pkg::ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 2'd3));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1048, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1052, 32'd5, 2'd3));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1007, 32'd5, 2'd1));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd3118, 32'd5, 2'd2));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1053, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd0, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'hFFFF, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1047, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1076, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1234, 32'd5, 2'd0));
        // older second only raises the total
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1234, 32'd4, 2'd0));
        // status value three maps to other
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, 2'd3));
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1119, 32'd5, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_OTHER));
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_SHUNNED));
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        send_word(mk_word(cfsm_pkg::ACT_KILL_ALL, 16'hFFFF, 32'hFFFF_FFFF, 2'd3));
        // marks survive a status write
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1234, 32'd6, 2'd0));
    endtask

    // zero and widest thresholds
    task automatic test_threshold_extremes();
        set_config(10'd0, 16'd0);
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd2000, 32'd100, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd2000, 32'd100, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd2001, 32'd100, 2'd0));
        set_config(10'd1000, 16'd65535);
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd2002, 32'd100, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd2003, 32'd101, 2'd0));
        set_config(10'd0, 16'd65535);
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd2004, 32'd101, 2'd0));
    endtask

    // random phases, each with its own register setting
    task automatic test_random_phases();
        logic [9:0] retries;
        logic [15:0] shun;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            retries = ($urandom_range(0, 1) == 1) ? 10'($urandom_range(0, 12))
                                                  : 10'($urandom_range(0, 1000));
            shun = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 9))
                                               : 16'($urandom_range(0, 65535));
            if (p == 0)
            begin
                retries = 10'd1000;
                shun = 16'd3;
            end
            set_config(retries, shun);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 40 == 0)
                    no_idle = (p % 3 == 2) || ($urandom_range(0, 3) == 0);
                send_word(random_word());
            end
        end
        no_idle = 1'b0;
    endtask

    // result side holds off while words keep coming
    task automatic test_backpressure();
        drain();
        no_idle = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_word(random_word());
        no_idle = 1'b0;
    endtask

    // long burst in one second that crosses a wide threshold
    task automatic test_long_burst();
        logic [31:0] sec;
        set_config(10'd1000, 16'd150);
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        sec = last_sec + 32'd1;
        no_idle = 1'b1;
        for (int n = 0; n < BURST_WORDS; n++)
            send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd4000, sec, 2'd0));
        no_idle = 1'b0;
    endtask

    // the last second of the time range, then a wrapped time
    task automatic test_last_second();
        set_config(10'd4, 16'd2);
        send_word(mk_word(cfsm_pkg::ACT_SET_STATUS, 16'd0, 32'd0, cfsm_pkg::ST_ONLINE));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1115, 32'hFFFF_FFFF, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1115, 32'hFFFF_FFFF, 2'd0));
        send_word(mk_word(cfsm_pkg::ACT_CONNECT_ERROR, 16'd1115, 32'd0, 2'd0));
    endtask

    // main sequence
    initial
    begin
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_threshold_extremes();
        test_random_phases();
        test_backpressure();
        test_long_burst();
        test_last_second();
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/cfsm_pkg.sv
design/cfsm_front.sv
design/cfsm_exec.sv
design/connect_failure_shun_monitor.sv
design/cfsm_checker.sv
bench/testbench.sv
